[rtl/core/credit_flow_output_queue_assert.svh]
// ---------------------------------------------------------------------------
// credit_flow_output_queue_assert.svh
// Assertion macros for the credit flow output queue. Define ASSERT_OFF to
// compile them away.
// ---------------------------------------------------------------------------
`ifndef CREDIT_FLOW_OUTPUT_QUEUE_ASSERT_SVH
`define CREDIT_FLOW_OUTPUT_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition must never hold outside reset.
`define CFOQ_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

// Antecedent implies consequent on the same edge.
`define CFOQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication broken");

`else

`define CFOQ_ASSERT_NEVER(label, clk, rst, cond)
`define CFOQ_ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

[rtl/core/cfoq_pkg.sv]
// ---------------------------------------------------------------------------
// cfoq_pkg
// Shared constants, widths and control and status types of the credit flow output queue.
// ---------------------------------------------------------------------------
package cfoq_pkg;

  // Sizing
  localparam int QUEUE_DEPTH  = 4;
  localparam int ROUTER_DEPTH = 4;
  localparam int FLIT_BITS    = 32;

  // Stored flit width: the port carries 32 bits, FLIT_BITS may trim it
  localparam int STORE_W  = (FLIT_BITS < 32) ? FLIT_BITS : 32;
  localparam int IDX_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int CREDIT_W = $clog2(ROUTER_DEPTH + 2);

  // Port field widths
  localparam int FLIT_W      = 32;
  localparam int CRED_OUT_W  = 3;
  localparam int S_DATA_W    = 40;
  localparam int M_DATA_W    = 40;

  // Queue control from the top level
  typedef struct packed {
    logic pop;
    logic push;
  } fq_ctl_t;

  // Queue status: not_empty is current, the rest are after this beat
  typedef struct packed {
    logic not_empty;
    logic almost_full;
    logic empty;
    logic dropped;
  } fq_stat_t;

endpackage

[rtl/core/cfoq_fifo.sv]
// ---------------------------------------------------------------------------
// cfoq_fifo
// Circular flit buffer with head/tail pointers and a fill count; pop is
// applied before push so a full queue that sends can still store.
// ---------------------------------------------------------------------------
module cfoq_fifo
  import cfoq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  fq_ctl_t            ctl,
  input  logic [STORE_W-1:0] push_flit,
  output logic [STORE_W-1:0] head_flit,
  output fq_stat_t           stat
);

  logic [STORE_W-1:0] flit_store [QUEUE_DEPTH];
  logic [IDX_W-1:0]   head_index;
  logic [IDX_W-1:0]   tail_index;
  logic [CNT_W-1:0]   fill_count;

  logic [IDX_W-1:0]   head_index_next;
  logic [IDX_W-1:0]   tail_index_next;
  logic [CNT_W-1:0]   fill_count_next;
  logic [CNT_W-1:0]   fill_after_pop;
  logic               room;
  logic               store;

  // Read the head entry
  assign head_flit = flit_store[head_index];

  // Pop first, then decide whether the push fits
  always_comb begin
    fill_after_pop  = fill_count - CNT_W'(ctl.pop);
    room            = (fill_after_pop != CNT_W'(QUEUE_DEPTH));
    store           = ctl.push & room;
    fill_count_next = fill_after_pop + CNT_W'(store);

    head_index_next = head_index;
    if (ctl.pop) begin
      head_index_next = (head_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_index + 1'b1;
    end
    tail_index_next = tail_index;
    if (store) begin
      tail_index_next = (tail_index == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : tail_index + 1'b1;
    end

    stat.not_empty   = (fill_count != '0);
    stat.almost_full = (fill_count_next >= CNT_W'(QUEUE_DEPTH - 1));
    stat.empty       = (fill_count_next == '0);
    stat.dropped     = ctl.push & ~room;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      tail_index <= '0;
      fill_count <= '0;
    end else begin
      head_index <= head_index_next;
      tail_index <= tail_index_next;
      fill_count <= fill_count_next;
    end
  end

  // Write the stored flit
  always_ff @(posedge clk) begin
    if (store) begin
      flit_store[tail_index] <= push_flit;
    end
  end

endmodule

[rtl/core/cfoq_credit.sv]
// ---------------------------------------------------------------------------
// cfoq_credit
// Credit counter for the router input buffer: spend one per send, add one
// per returned credit, saturate at the router buffer depth.
// ---------------------------------------------------------------------------
module cfoq_credit
  import cfoq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                spend,
  input  logic                ret,
  output logic                has_credit,
  output logic [CREDIT_W-1:0] credits_next
);

  logic [CREDIT_W-1:0] credit_count;
  logic [CREDIT_W-1:0] sum;

  assign has_credit = (credit_count != '0);

  // Spend first, then add the return with saturation
  always_comb begin
    sum          = credit_count - CREDIT_W'(spend) + CREDIT_W'(ret);
    credits_next = (sum > CREDIT_W'(ROUTER_DEPTH)) ? CREDIT_W'(ROUTER_DEPTH) : sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit_count <= CREDIT_W'(ROUTER_DEPTH);
    end else begin
      credit_count <= credits_next;
    end
  end

endmodule

[rtl/core/credit_flow_output_queue.sv]
// ---------------------------------------------------------------------------
// credit_flow_output_queue
// Flit output queue toward a router port, gated by credits for the router's
// input buffer.
// ---------------------------------------------------------------------------
// Each input beat is one tick: it may offer a flit and return a credit, and
// it yields exactly one result beat telling whether the head flit was sent,
// the flit itself, the queue flags, whether the offered flit was dropped,
// and the credits left. A beat is registered at the input, evaluated
// combinationally by the queue and credit logic, and held in a result
// register; one beat per clock is sustained while m_tready holds. The
// result beat is registered in the result register after the input register
// has taken the input beat, and it leaves when m_tready accepts it. The flow
// stalls only while the result register is stalled by m_tready.
`include "credit_flow_output_queue_assert.svh"

module credit_flow_output_queue
  import cfoq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // [0] push_valid, [32:1] push_flit, [33] credit_return, [39:34] zero
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] send_valid, [32:1] send_flit, [33] almost_full, [34] queue_empty,
  // [35] push_dropped, [38:36] credits_left, [39] zero
  output logic [M_DATA_W-1:0] m_tdata
);

  // Input register
  logic              in_valid;
  logic              in_push;
  logic [FLIT_W-1:0] in_flit;
  logic              in_ret;

  // Result register
  logic                  out_valid;
  logic                  out_send;
  logic [FLIT_W-1:0]     out_flit;
  logic                  out_almost_full;
  logic                  out_empty;
  logic                  out_dropped;
  logic [CRED_OUT_W-1:0] out_credits;

  logic                  advance;
  fq_ctl_t               fifo_ctl;
  fq_stat_t              fifo_stat;
  logic [STORE_W-1:0]    head_flit;
  logic                  has_credit;
  logic [CREDIT_W-1:0]   credits_next;
  logic [STORE_W+FLIT_W-1:0]       flit_ext;
  logic [CREDIT_W+CRED_OUT_W-1:0]  credit_ext;

  // Evaluate a beat when the result register is free or draining
  assign advance  = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | advance;

  // Send when a flit waits and a credit remains
  always_comb begin
    fifo_ctl.pop  = advance & fifo_stat.not_empty & has_credit;
    fifo_ctl.push = advance & in_push;
  end

  cfoq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fifo_ctl),
    .push_flit (in_flit[STORE_W-1:0]),
    .head_flit (head_flit),
    .stat      (fifo_stat)
  );

  cfoq_credit u_credit (
    .clk          (clk),
    .rst          (rst),
    .spend        (fifo_ctl.pop),
    .ret          (advance & in_ret),
    .has_credit   (has_credit),
    .credits_next (credits_next)
  );

  assign flit_ext   = {{FLIT_W{1'b0}}, head_flit};
  assign credit_ext = {{CRED_OUT_W{1'b0}}, credits_next};

  // Capture an input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_push <= s_tdata[0];
      in_flit <= s_tdata[FLIT_W:1];
      in_ret  <= s_tdata[FLIT_W+1];
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_send        <= fifo_ctl.pop;
      out_flit        <= fifo_ctl.pop ? flit_ext[FLIT_W-1:0] : '0;
      out_almost_full <= fifo_stat.almost_full;
      out_empty       <= fifo_stat.empty;
      out_dropped     <= fifo_stat.dropped;
      out_credits     <= credit_ext[CRED_OUT_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_credits, out_dropped, out_empty, out_almost_full,
                     out_flit, out_send};

  // A send frees a slot, so the same beat can never drop its flit
  `CFOQ_ASSERT_NEVER(a_no_drop_on_send, clk, rst, fifo_ctl.pop && fifo_stat.dropped)
  // The credit count never passes the router buffer depth
  `CFOQ_ASSERT_NEVER(a_credit_bound, clk, rst, credits_next > CREDIT_W'(ROUTER_DEPTH))
  // A flit is only sent from a non-empty queue with a credit in hand
  `CFOQ_ASSERT_IMPLY(a_send_ok, clk, rst, fifo_ctl.pop, fifo_stat.not_empty && has_credit && advance)

endmodule

[bench/credit_flow_output_queue_tb.sv]
// ---------------------------------------------------------------------------
// credit_flow_output_queue_tb
// Self-checking bench for the credit flow output queue. A directed table
// walks the FIFO through empty, full, drop, credit exhaustion and credit
// saturation. Random phases with varied push and credit-return rates follow.
// Each result beat is checked field by field against a shadow queue and credit
// counter or a pinned expected result, with random idle bursts on both streams.
// ---------------------------------------------------------------------------
module credit_flow_output_queue_tb;
  import cfoq_pkg::*;

  localparam int NUM_DIRECTED = 25;
  localparam int NUM_RANDOM   = 1800;
  localparam int QUIET_TAIL   = 200;
  localparam int PHASE_LEN    = 120;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 400000;

  // One result beat, unpacked from m_tdata
  typedef struct packed {
    logic        send;
    logic [31:0] flit;
    logic        almost_full;
    logic        empty;
    logic        dropped;
    logic [2:0]  credits;
  } queue_res_t;

  // One directed row; pinned rows carry a hand-written expected result
  typedef struct packed {
    logic        push;
    logic [31:0] flit;
    logic        ret;
    logic        pinned;
    queue_res_t  want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;

  plan_row_t  plan [NUM_DIRECTED];
  queue_res_t awaited_results [$];

  // Shadow of the queue and the credit counter
  logic [31:0] shadow_flits [QUEUE_DEPTH];
  int          shadow_head;
  int          shadow_tail;
  int          shadow_fill;
  int          shadow_credits;

  int          beats_in = 0;
  int          beats_out = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          stall_left = 0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;

  credit_flow_output_queue u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Send one flit if a credit remains, take a returned credit, then store
  // the offered flit if the pop left room
  function automatic queue_res_t send_and_enqueue(logic push, logic [31:0] flit,
                                                  logic ret);
    queue_res_t  res;
    logic [63:0] keep_mask;
    res = '0;
    keep_mask = (64'd1 << FLIT_BITS) - 64'd1;
    if (shadow_fill > 0 && shadow_credits >= 1) begin
      res.send = 1'b1;
      res.flit = shadow_flits[shadow_head];
      shadow_head = (shadow_head + 1 >= QUEUE_DEPTH) ? 0 : shadow_head + 1;
      shadow_fill--;
      shadow_credits--;
    end
    if (ret) begin
      shadow_credits++;
      if (shadow_credits > ROUTER_DEPTH) shadow_credits = ROUTER_DEPTH;
    end
    if (push) begin
      if (shadow_fill < QUEUE_DEPTH) begin
        shadow_flits[shadow_tail] = flit & keep_mask[31:0];
        shadow_tail = (shadow_tail + 1 >= QUEUE_DEPTH) ? 0 : shadow_tail + 1;
        shadow_fill++;
      end else begin
        res.dropped = 1'b1;
      end
    end
    res.almost_full = (shadow_fill + 1 >= QUEUE_DEPTH);
    res.empty = (shadow_fill == 0);
    res.credits = shadow_credits[2:0];
    return res;
  endfunction

  // Cycle watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Output backpressure: random stall bursts on m_tready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 8);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Check result beats first, then predict the input beat taken at this edge
  always @(posedge clk) begin
    queue_res_t got;
    queue_res_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.send        = m_tdata[0];
        got.flit        = m_tdata[32:1];
        got.almost_full = m_tdata[33];
        got.empty       = m_tdata[34];
        got.dropped     = m_tdata[35];
        got.credits     = m_tdata[38:36];
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result beat %0d arrived with nothing pending: %p", beats_out, got);
        end else begin
          want = awaited_results.pop_front();
          if (got.send !== want.send || got.flit !== want.flit ||
              got.almost_full !== want.almost_full || got.empty !== want.empty ||
              got.dropped !== want.dropped || got.credits !== want.credits) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result beat %0d mismatch", beats_out);
              $display("  expected send=%b flit=%h afull=%b empty=%b drop=%b cred=%0d",
                       want.send, want.flit, want.almost_full, want.empty,
                       want.dropped, want.credits);
              $display("  actual   send=%b flit=%h afull=%b empty=%b drop=%b cred=%0d",
                       got.send, got.flit, got.almost_full, got.empty,
                       got.dropped, got.credits);
            end
          end
        end
        beats_out++;
      end
      if (s_tvalid && s_tready) begin
        want = send_and_enqueue(s_tdata[0], s_tdata[32:1], s_tdata[33]);
        if (beats_in < NUM_DIRECTED && plan[beats_in].pinned) want = plan[beats_in].want;
        awaited_results.push_back(want);
        beats_in++;
      end
    end
  end

  // Present one input beat and hold it until it is taken
  task automatic offer_beat(logic push, logic [31:0] flit, logic ret);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, ret, flit, push};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin
    int          push_pct;
    int          ret_pct;
    int          idle_mode;
    int          waited;
    logic        push;
    logic        ret;
    logic [31:0] flit;

    shadow_head = 0;
    shadow_tail = 0;
    shadow_fill = 0;
    shadow_credits = ROUTER_DEPTH;
    foreach (shadow_flits[i]) shadow_flits[i] = '0;

    // push, flit, credit return, pinned, expected result
    plan = '{
      // idle after reset
      '{1'b0, 32'hFFFF_FFFF, 1'b0, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b1, 1'b0, 3'd4}},
      // credit returned while already full of credits
      '{1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 3'd4}},
      '{1'b1, 32'h0000_0000, 1'b0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 3'd3}},
      '{1'b1, 32'hA5A5_A5A5, 1'b0, 1'b0, '0},
      '{1'b1, 32'h5A5A_5A5A, 1'b0, 1'b0, '0},
      '{1'b1, 32'h1234_5678, 1'b0, 1'b0, '0},
      // credit returned at zero credits counts only from the next beat
      '{1'b1, 32'h8000_0000, 1'b1, 1'b1, '{1'b0, 32'h0, 1'b0, 1'b0, 1'b0, 3'd1}},
      '{1'b1, 32'h0000_0001, 1'b0, 1'b0, '0},
      '{1'b1, 32'hDEAD_BEEF, 1'b0, 1'b0, '0},
      '{1'b1, 32'hCAFE_F00D, 1'b0, 1'b0, '0},
      // full queue, no credit: offered flit is dropped
      '{1'b1, 32'h0F0F_0F0F, 1'b0, 1'b1, '{1'b0, 32'h0, 1'b1, 1'b0, 1'b1, 3'd0}},
      // full queue, no push offered: nothing dropped
      '{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b0, '0},
      // full queue with push: the pop in the same beat frees a slot
      '{1'b1, 32'hF0F0_F0F0, 1'b0, 1'b0, '0},
      // drain, then refill credits past the router depth
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b1, 1'b0, '0},
      '{1'b1, 32'h7FFF_FFFF, 1'b1, 1'b0, '0},
      '{1'b1, 32'hFFFF_FFFE, 1'b1, 1'b0, '0},
      '{1'b0, 32'h0000_0000, 1'b0, 1'b0, '0}
    };

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with light idling on both sides
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      offer_beat(plan[r].push, plan[r].flit, plan[r].ret);
    end

    // Random phases: vary push and credit rates to reach full, drop and starve
    push_pct = 50;
    ret_pct = 50;
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 15;
          1: push_pct = 50;
          2: push_pct = 85;
          default: push_pct = 100;
        endcase
        case ($urandom_range(0, 4))
          0: ret_pct = 0;
          1: ret_pct = 20;
          2: ret_pct = 50;
          3: ret_pct = 80;
          default: ret_pct = 100;
        endcase
        idle_mode = $urandom_range(0, 3);
        tx_idle_on = (n < NUM_RANDOM - QUIET_TAIL) && idle_mode[0];
        rx_idle_on = (n < NUM_RANDOM - QUIET_TAIL) && idle_mode[1];
      end
      if (n == NUM_RANDOM - QUIET_TAIL) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      push = ($urandom_range(1, 100) <= push_pct);
      ret = ($urandom_range(1, 100) <= ret_pct);
      case ($urandom_range(0, 9))
        0: flit = 32'h0000_0000;
        1: flit = 32'hFFFF_FFFF;
        2: flit = 32'h1 << $urandom_range(0, 31);
        default: flit = $urandom;
      endcase
      offer_beat(push, flit, ret);
    end
    s_tvalid <= 1'b0;

    // Wait out the pending results, then keep watching for strays before the check
    waited = 0;
    while (awaited_results.size() != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      mismatches++;
      $display("%0d result beats never arrived", awaited_results.size());
    end

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/cfoq_pkg.sv
rtl/core/cfoq_fifo.sv
rtl/core/cfoq_credit.sv
rtl/core/credit_flow_output_queue.sv
bench/credit_flow_output_queue_tb.sv
